// ----- rtl/drdm_pkg.sv -----
// Package for the battery drain-rate monitor: field widths, limits, register
// indexes and the job record passed from the front end to the back end.
// No dependencies.
package drdm_pkg;

  // Default sizing, used as the defaults of the top level parameters.
  localparam int CHANNELS_DEF = 3;
  localparam int WINDOW_DEF   = 10;

  // Field widths fixed by the interface.
  localparam int CH_W      = 2;
  localparam int LEVEL_W   = 14;
  localparam int TIME_W    = 32;
  localparam int RATE_W    = 24;
  localparam int CRIT_W    = 14;
  localparam int EST_W     = 14;

  // Limits and scale.
  localparam int unsigned LEVEL_MAX  = 10000;
  localparam int unsigned RATE_SCALE = 1000;

  // Divider: 24-bit dividend, 31-bit divisor, two quotient bits a cycle.
  localparam int NUMER_W    = RATE_W;
  localparam int DIV_W      = TIME_W - 1;
  localparam int STEP_W     = 4;
  localparam int RATE_STEPS = NUMER_W / 2;
  localparam int EST_STEPS  = LEVEL_W / 2;
  localparam int PAD_W      = NUMER_W - LEVEL_W;

  // Work queue between front and back end (power of two).
  localparam int QUEUE_DEPTH = 2;

  // Configuration registers.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LEVEL  = 1'd1;
  localparam logic [RATE_W-1:0]    DRAIN_THRESHOLD_RST = 24'd150;
  localparam logic [CRIT_W-1:0]    CRITICAL_LEVEL_RST  = 14'd2500;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic               rate_valid;
    logic               do_rate;
    logic [LEVEL_W-1:0] level;
    logic [NUMER_W-1:0] numer;
    logic [DIV_W-1:0]   elapsed;
  } job_t;

endpackage

// ----- rtl/drdm_ram.sv -----
// Generic single write port / single read port RAM with registered read.
// No dependencies.
module drdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/drdm_front.sv -----
// Front end: accepts samples, updates the per-channel ring windows and builds
// the job record for the back end. Uses drdm_pkg and drdm_ram.
module drdm_front #(
  parameter int CHANNELS = drdm_pkg::CHANNELS_DEF,
  parameter int WINDOW   = drdm_pkg::WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [drdm_pkg::CH_W-1:0]    in_channel,
  input  logic [drdm_pkg::LEVEL_W-1:0] in_battery_level,
  input  logic [drdm_pkg::TIME_W-1:0]  in_timestamp_ms,
  output logic                         q_push,
  input  logic                         q_full,
  output drdm_pkg::job_t               q_job
);

  localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int PW    = $clog2(WINDOW);
  localparam int AW    = $clog2(CHANNELS * WINDOW);
  localparam int EW    = drdm_pkg::TIME_W + drdm_pkg::LEVEL_W;

  logic [FW-1:0] fill_r [CHANNELS];
  logic [PW-1:0] old_r  [CHANNELS];

  logic                         s1_valid_r;
  logic [drdm_pkg::CH_W-1:0]    s1_ch_r;
  logic                         s1_in_range_r;
  logic                         s1_rate_valid_r;
  logic [drdm_pkg::LEVEL_W-1:0] s1_level_r;
  logic [drdm_pkg::TIME_W-1:0]  s1_time_r;

  logic                         accept;
  logic                         in_range;
  logic [CH_IW-1:0]             ch_idx;
  logic [drdm_pkg::LEVEL_W-1:0] level_sat;
  logic [FW-1:0]                fill;
  logic [PW-1:0]                old;
  logic [PW:0]                  pos_sum;
  logic [PW-1:0]                wpos;
  logic [PW-1:0]                old_nxt;
  logic [FW-1:0]                fill_nxt;
  logic [AW-1:0]                base;
  logic                         wr_en;
  logic [EW-1:0]                rd_data;
  logic [drdm_pkg::TIME_W-1:0]  t0;
  logic [drdm_pkg::LEVEL_W-1:0] l0;
  logic [drdm_pkg::TIME_W-1:0]  diff;
  logic [drdm_pkg::LEVEL_W-1:0] drop;

  assign in_stall = s1_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = s1_valid_r && !q_full;

  assign in_range  = (32'(in_channel) < CHANNELS);
  assign ch_idx    = CH_IW'(in_channel);
  assign level_sat = (in_battery_level > drdm_pkg::LEVEL_W'(drdm_pkg::LEVEL_MAX)) ?
                     drdm_pkg::LEVEL_W'(drdm_pkg::LEVEL_MAX) : in_battery_level;

  assign fill    = fill_r[ch_idx];
  assign old     = old_r[ch_idx];
  assign pos_sum = {1'b0, old} + (PW+1)'(fill);

  // Full window overwrites the oldest entry and advances it; otherwise append.
  always_comb begin
    if (fill == FW'(WINDOW)) begin
      wpos     = old;
      old_nxt  = (old == PW'(WINDOW - 1)) ? '0 : PW'(old + 1'b1);
      fill_nxt = fill;
    end else begin
      wpos     = (pos_sum >= (PW+1)'(WINDOW)) ? PW'(pos_sum - (PW+1)'(WINDOW)) : PW'(pos_sum);
      old_nxt  = old;
      fill_nxt = FW'(fill + 1'b1);
    end
  end

  assign base  = AW'(32'(ch_idx) * WINDOW);
  assign wr_en = accept && in_range;

  // Read and write addresses differ whenever the read entry is used.
  drdm_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS * WINDOW)
  ) u_win_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(base + AW'(wpos))),
    .wr_data ({in_timestamp_ms, level_sat}),
    .rd_en   (wr_en),
    .rd_addr (AW'(base + AW'(old_nxt))),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        fill_r[i] <= '0;
        old_r[i]  <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (q_push) begin
        s1_valid_r <= 1'b0;
      end
      if (wr_en) begin
        fill_r[ch_idx] <= fill_nxt;
        old_r[ch_idx]  <= old_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch_r         <= in_channel;
      s1_in_range_r   <= in_range;
      s1_rate_valid_r <= in_range && (fill_nxt >= FW'(2));
      s1_level_r      <= level_sat;
      s1_time_r       <= in_timestamp_ms;
    end
  end

  assign t0   = rd_data[EW-1:drdm_pkg::LEVEL_W];
  assign l0   = rd_data[drdm_pkg::LEVEL_W-1:0];
  assign diff = s1_time_r - t0;
  assign drop = l0 - s1_level_r;

  // Clock wrap: elapsed time is the modular difference read as signed.
  always_comb begin
    q_job.ch         = s1_ch_r;
    q_job.rate_valid = s1_rate_valid_r;
    q_job.do_rate    = s1_in_range_r && s1_rate_valid_r && (diff != '0) &&
                       !diff[drdm_pkg::TIME_W-1] && (l0 > s1_level_r);
    q_job.level      = s1_level_r;
    q_job.numer      = drdm_pkg::NUMER_W'(drop) *
                       drdm_pkg::NUMER_W'(drdm_pkg::RATE_SCALE);
    q_job.elapsed    = diff[drdm_pkg::DIV_W-1:0];
  end

endmodule

// ----- rtl/drdm_fifo.sv -----
// Short job queue between the front and back ends.
// Uses drdm_pkg (job_t, QUEUE_DEPTH).
module drdm_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  drdm_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output drdm_pkg::job_t pop_data
);

  localparam int QW = $clog2(drdm_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(drdm_pkg::QUEUE_DEPTH + 1);

  drdm_pkg::job_t entry_r [drdm_pkg::QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr_r;
  logic [QW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full     = (count_r == CW'(drdm_pkg::QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= QW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= QW'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/drdm_div.sv -----
// Shared restoring divider, two quotient bits per cycle.
// Uses drdm_pkg for widths. Quotient lands in the low 2*steps bits.
module drdm_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [drdm_pkg::NUMER_W-1:0] dividend,
  input  logic [drdm_pkg::DIV_W-1:0]   divisor,
  input  logic [drdm_pkg::STEP_W-1:0]  steps,
  output logic                         done,
  output logic [drdm_pkg::NUMER_W-1:0] quotient
);

  logic                         busy_r;
  logic                         done_r;
  logic [drdm_pkg::STEP_W-1:0]  cnt_r;
  logic [drdm_pkg::DIV_W-1:0]   rem_r;
  logic [drdm_pkg::DIV_W-1:0]   dvs_r;
  logic [drdm_pkg::NUMER_W-1:0] dq_r;

  logic [drdm_pkg::DIV_W:0]     trial1;
  logic [drdm_pkg::DIV_W:0]     trial2;
  logic                         ge1;
  logic                         ge2;
  logic [drdm_pkg::DIV_W-1:0]   rem1;
  logic [drdm_pkg::DIV_W-1:0]   rem2;

  always_comb begin
    trial1 = {rem_r, dq_r[drdm_pkg::NUMER_W-1]};
    ge1    = (trial1 >= {1'b0, dvs_r});
    rem1   = ge1 ? drdm_pkg::DIV_W'(trial1 - {1'b0, dvs_r}) : drdm_pkg::DIV_W'(trial1);
    trial2 = {rem1, dq_r[drdm_pkg::NUMER_W-2]};
    ge2    = (trial2 >= {1'b0, dvs_r});
    rem2   = ge2 ? drdm_pkg::DIV_W'(trial2 - {1'b0, dvs_r}) : drdm_pkg::DIV_W'(trial2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == drdm_pkg::STEP_W'(1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == drdm_pkg::STEP_W'(1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= steps;
    end else if (busy_r) begin
      dq_r  <= {dq_r[drdm_pkg::NUMER_W-3:0], ge1, ge2};
      rem_r <= rem2;
      cnt_r <= drdm_pkg::STEP_W'(cnt_r - 1'b1);
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

// ----- rtl/drdm_back.sv -----
// Back end: runs rate and time estimates through the shared divider and holds
// the result register. Uses drdm_pkg and drdm_div.
module drdm_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  drdm_pkg::job_t                  q_job,
  output logic                            q_pop,
  input  logic [drdm_pkg::RATE_W-1:0]     drain_threshold,
  input  logic [drdm_pkg::CRIT_W-1:0]     critical_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [drdm_pkg::CH_W-1:0]       out_source_channel,
  output logic                            out_rate_valid,
  output logic [drdm_pkg::RATE_W-1:0]     out_drain_rate,
  output logic                            out_high_drain,
  output logic                            out_estimate_finite,
  output logic [drdm_pkg::EST_W-1:0]      out_seconds_to_critical,
  output logic [drdm_pkg::EST_W-1:0]      out_seconds_to_depletion
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_CRIT,
    ST_DEP,
    ST_DONE
  } state_t;

  state_t                       state_r;
  drdm_pkg::job_t               job_r;
  logic [drdm_pkg::RATE_W-1:0]  rate_r;
  logic [drdm_pkg::EST_W-1:0]   tcrit_r;
  logic [drdm_pkg::EST_W-1:0]   tdep_r;
  logic                         div_start_r;
  logic [drdm_pkg::NUMER_W-1:0] div_dvd_r;
  logic [drdm_pkg::DIV_W-1:0]   div_dvs_r;
  logic [drdm_pkg::STEP_W-1:0]  div_steps_r;
  logic                         out_valid_r;

  logic                         div_start_nxt;
  logic                         div_done;
  logic [drdm_pkg::NUMER_W-1:0] div_quo;
  logic [drdm_pkg::LEVEL_W-1:0] above_crit;

  drdm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .steps    (div_steps_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign above_crit = job_r.level - critical_level;

  // Divider kicks off for a new rate job, after a nonzero rate, and after the
  // time to critical.
  assign div_start_nxt = ((state_r == ST_IDLE) && q_valid && q_job.do_rate) ||
                         ((state_r == ST_RATE) && div_done && (div_quo != '0)) ||
                         ((state_r == ST_CRIT) && div_done);

  // Rate is at most 10000 * 1000 and the estimates at most 10000, so no
  // saturation stage is needed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= div_start_nxt;
      if ((state_r == ST_DONE) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            job_r <= q_job;
            if (q_job.do_rate) begin
              div_dvd_r   <= q_job.numer;
              div_dvs_r   <= q_job.elapsed;
              div_steps_r <= drdm_pkg::STEP_W'(drdm_pkg::RATE_STEPS);
              state_r     <= ST_RATE;
            end else begin
              rate_r  <= '0;
              tcrit_r <= '0;
              tdep_r  <= '0;
              state_r <= ST_DONE;
            end
          end
        end
        ST_RATE: begin
          if (div_done) begin
            rate_r  <= div_quo;
            tcrit_r <= '0;
            tdep_r  <= '0;
            if (div_quo == '0) begin
              state_r <= ST_DONE;
            end else begin
              div_dvs_r   <= drdm_pkg::DIV_W'(div_quo);
              div_steps_r <= drdm_pkg::STEP_W'(drdm_pkg::EST_STEPS);
              if (job_r.level > critical_level) begin
                div_dvd_r <= {above_crit, {drdm_pkg::PAD_W{1'b0}}};
                state_r   <= ST_CRIT;
              end else begin
                div_dvd_r <= {job_r.level, {drdm_pkg::PAD_W{1'b0}}};
                state_r   <= ST_DEP;
              end
            end
          end
        end
        ST_CRIT: begin
          if (div_done) begin
            tcrit_r   <= div_quo[drdm_pkg::EST_W-1:0];
            div_dvd_r <= {job_r.level, {drdm_pkg::PAD_W{1'b0}}};
            state_r   <= ST_DEP;
          end
        end
        ST_DEP: begin
          if (div_done) begin
            tdep_r  <= div_quo[drdm_pkg::EST_W-1:0];
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_source_channel       <= job_r.ch;
            out_rate_valid           <= job_r.rate_valid;
            out_drain_rate           <= rate_r;
            out_high_drain           <= job_r.rate_valid && (rate_r > drain_threshold);
            out_estimate_finite      <= (rate_r != '0);
            out_seconds_to_critical  <= tcrit_r;
            out_seconds_to_depletion <= tdep_r;
            state_r                  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/battery_drain_rate_monitor.sv -----
// Battery drain-rate monitor, top level: config registers, front end, job
// queue and back end. Uses drdm_pkg, drdm_front, drdm_fifo and drdm_back.
// Path from accept to result: front-end sample register, job queue, back end
// (idle, then the rate, time-to-critical and time-to-empty divisions as
// needed, then done) and result register. The back end holds one item at a
// time and runs the shared 2-bit-per-cycle divider up to three times per item.
// Reset (rst_n low, synchronous) empties every window, the queue and the
// result register, and loads threshold 150 and critical level 2500.
module battery_drain_rate_monitor #(
  parameter int CHANNELS = drdm_pkg::CHANNELS_DEF,
  parameter int WINDOW   = drdm_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [drdm_pkg::CH_W-1:0]       in_channel,
  input  logic [drdm_pkg::LEVEL_W-1:0]    in_battery_level,
  input  logic [drdm_pkg::TIME_W-1:0]     in_timestamp_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [drdm_pkg::CH_W-1:0]       out_source_channel,
  output logic                            out_rate_valid,
  output logic [drdm_pkg::RATE_W-1:0]     out_drain_rate,
  output logic                            out_high_drain,
  output logic                            out_estimate_finite,
  output logic [drdm_pkg::EST_W-1:0]      out_seconds_to_critical,
  output logic [drdm_pkg::EST_W-1:0]      out_seconds_to_depletion,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drdm_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [drdm_pkg::RATE_W-1:0] drain_threshold_r;
  logic [drdm_pkg::CRIT_W-1:0] critical_level_r;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  drdm_pkg::job_t front_job;
  drdm_pkg::job_t back_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_threshold_r <= drdm_pkg::DRAIN_THRESHOLD_RST;
      critical_level_r  <= drdm_pkg::CRITICAL_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        drdm_pkg::CFG_DRAIN_THRESHOLD: drain_threshold_r <= cfg_data[drdm_pkg::RATE_W-1:0];
        drdm_pkg::CFG_CRITICAL_LEVEL:  critical_level_r  <= cfg_data[drdm_pkg::CRIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  drdm_front #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_channel       (in_channel),
    .in_battery_level (in_battery_level),
    .in_timestamp_ms  (in_timestamp_ms),
    .q_push           (q_push),
    .q_full           (q_full),
    .q_job            (front_job)
  );

  drdm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (back_job)
  );

  drdm_back u_back (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .q_valid                  (q_valid),
    .q_job                    (back_job),
    .q_pop                    (q_pop),
    .drain_threshold          (drain_threshold_r),
    .critical_level           (critical_level_r),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_source_channel       (out_source_channel),
    .out_rate_valid           (out_rate_valid),
    .out_drain_rate           (out_drain_rate),
    .out_high_drain           (out_high_drain),
    .out_estimate_finite      (out_estimate_finite),
    .out_seconds_to_critical  (out_seconds_to_critical),
    .out_seconds_to_depletion (out_seconds_to_depletion)
  );

`ifndef SYNTHESIS
  a_no_rate_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rate_valid |-> out_drain_rate == '0)
    else $error("drain rate set without a valid window");

  a_high_needs_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_high_drain |-> out_rate_valid && out_estimate_finite)
    else $error("high drain flagged without a nonzero rate");

  a_infinite_estimates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_estimate_finite |->
      out_seconds_to_critical == '0 && out_seconds_to_depletion == '0)
    else $error("estimates set while rate is zero");

  a_crit_before_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_seconds_to_critical <= out_seconds_to_depletion)
    else $error("time to critical exceeds time to depletion");
`endif

endmodule

// ----- tb/sv/tb_battery_drain_rate_monitor.sv -----
// Testbench for battery_drain_rate_monitor: directed and random battery samples,
// a bit-accurate drain-rate predictor and a result checker. Uses drdm_pkg.
// Random valid/stall bursts on input and output, plus one long result hold-off.
`timescale 1ns / 1ps

module tb_battery_drain_rate_monitor;

  localparam int unsigned RATE_CAP      = 10_000_000;
  localparam int unsigned EST_CAP       = 16383;
  localparam int unsigned LEVEL_TOP     = (1 << drdm_pkg::LEVEL_W) - 1;
  localparam int          SETTLE_CYCLES = 50;
  localparam int          LONG_HOLD     = 300;
  localparam int          QUIET_LIMIT   = 4000;

  typedef struct packed {
    logic [drdm_pkg::CH_W-1:0]    channel;
    logic [drdm_pkg::LEVEL_W-1:0] level;
    logic [drdm_pkg::TIME_W-1:0]  stamp;
  } sample_t;

  typedef struct packed {
    logic [drdm_pkg::CH_W-1:0]   channel;
    logic                        rate_valid;
    logic [drdm_pkg::RATE_W-1:0] rate_val;
    logic                        high_drain;
    logic                        est_finite;
    logic [drdm_pkg::EST_W-1:0]  to_crit;
    logic [drdm_pkg::EST_W-1:0]  to_empty;
  } drain_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [drdm_pkg::CH_W-1:0] in_channel = '0;
  logic [drdm_pkg::LEVEL_W-1:0] in_battery_level = '0;
  logic [drdm_pkg::TIME_W-1:0] in_timestamp_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [drdm_pkg::CH_W-1:0] out_source_channel;
  logic out_rate_valid;
  logic [drdm_pkg::RATE_W-1:0] out_drain_rate;
  logic out_high_drain;
  logic out_estimate_finite;
  logic [drdm_pkg::EST_W-1:0] out_seconds_to_critical;
  logic [drdm_pkg::EST_W-1:0] out_seconds_to_depletion;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [drdm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [drdm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  battery_drain_rate_monitor uut (.*);

  always #5 clk = ~clk;

  // Predictor state: per-channel sample windows and register copies.
  logic [drdm_pkg::TIME_W-1:0]  win_time  [drdm_pkg::CHANNELS_DEF][drdm_pkg::WINDOW_DEF];
  logic [drdm_pkg::LEVEL_W-1:0] win_level [drdm_pkg::CHANNELS_DEF][drdm_pkg::WINDOW_DEF];
  int unsigned win_fill [drdm_pkg::CHANNELS_DEF] = '{default: 0};
  int unsigned win_head [drdm_pkg::CHANNELS_DEF] = '{default: 0};
  logic [drdm_pkg::RATE_W-1:0] thr_reg  = drdm_pkg::DRAIN_THRESHOLD_RST;
  logic [drdm_pkg::CRIT_W-1:0] crit_reg = drdm_pkg::CRITICAL_LEVEL_RST;

  sample_t       pending_samples[$];
  drain_report_t expected_reports[$];

  // Stimulus generator state per channel
  logic [drdm_pkg::TIME_W-1:0] gen_time  [drdm_pkg::CHANNELS_DEF];
  int                          gen_level [drdm_pkg::CHANNELS_DEF];

  int  idle_pct = 20;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  int  send_gap = 0;
  int  hold_left = 0;
  bit  in_taken = 1'b0;
  int  quiet_cycles = 0;
  bit  failed = 1'b0;

  function automatic drain_report_t predict_drain_report(input sample_t s);
    drain_report_t r;
    int unsigned lvl, l0, slot, fill, head, rate, est;
    logic [drdm_pkg::TIME_W-1:0] elapsed;
    longint unsigned quot;
    r = '0;
    r.channel = s.channel;
    if (32'(s.channel) >= drdm_pkg::CHANNELS_DEF) return r;
    lvl  = (32'(s.level) > drdm_pkg::LEVEL_MAX) ? drdm_pkg::LEVEL_MAX : 32'(s.level);
    fill = win_fill[s.channel];
    head = win_head[s.channel];
    if (fill >= drdm_pkg::WINDOW_DEF) begin
      slot = head;
      head = (head + 1) % drdm_pkg::WINDOW_DEF;
    end else begin
      slot = (head + fill) % drdm_pkg::WINDOW_DEF;
      fill++;
    end
    win_time[s.channel][slot]  = s.stamp;
    win_level[s.channel][slot] = drdm_pkg::LEVEL_W'(lvl);
    win_fill[s.channel] = fill;
    win_head[s.channel] = head;
    rate = 0;
    if (fill >= 2) begin
      r.rate_valid = 1'b1;
      l0 = 32'(win_level[s.channel][head]);
      elapsed = s.stamp - win_time[s.channel][head];
      // wrap-safe: elapsed is read as a signed 32-bit difference
      if (elapsed != 0 && !elapsed[drdm_pkg::TIME_W-1] && l0 > lvl) begin
        quot = (64'(l0 - lvl) * drdm_pkg::RATE_SCALE) / 64'(elapsed);
        rate = (quot > RATE_CAP) ? RATE_CAP : 32'(quot);
      end
    end
    r.rate_val   = drdm_pkg::RATE_W'(rate);
    r.high_drain = r.rate_valid && (rate > 32'(thr_reg));
    if (rate > 0) begin
      r.est_finite = 1'b1;
      if (lvl > 32'(crit_reg)) begin
        est = (lvl - 32'(crit_reg)) / rate;
        r.to_crit = drdm_pkg::EST_W'((est > EST_CAP) ? EST_CAP : est);
      end
      est = lvl / rate;
      r.to_empty = drdm_pkg::EST_W'((est > EST_CAP) ? EST_CAP : est);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Sender: new item only when the previous one was taken or none is offered
  always @(negedge clk) begin : sample_driver
    sample_t next_sample;
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_samples.size() > 0 && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 17);
      end else if (pending_samples.size() > 0) begin
        next_sample = pending_samples[0];
        pending_samples.delete(0);
        in_valid <= 1'b1;
        in_channel <= next_sample.channel;
        in_battery_level <= next_sample.level;
        in_timestamp_ms <= next_sample.stamp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin : result_stall
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : report_monitor
    drain_report_t want, got;
    sample_t taken;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      taken = '{in_channel, in_battery_level, in_timestamp_ms};
      want = predict_drain_report(taken);
      expected_reports.insert(expected_reports.size(), want);
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_source_channel, out_rate_valid, out_drain_rate, out_high_drain,
              out_estimate_finite, out_seconds_to_critical, out_seconds_to_depletion};
      if (expected_reports.size() == 0) begin
        $error("unexpected result item: source_channel %0d", got.channel);
        failed = 1'b1;
      end else begin
        want = expected_reports[0];
        expected_reports.delete(0);
        check_field("out_source_channel", want.channel, got.channel);
        check_field("out_rate_valid", want.rate_valid, got.rate_valid);
        check_field("out_drain_rate", want.rate_val, got.rate_val);
        check_field("out_high_drain", want.high_drain, got.high_drain);
        check_field("out_estimate_finite", want.est_finite, got.est_finite);
        check_field("out_seconds_to_critical", want.to_crit, got.to_crit);
        check_field("out_seconds_to_depletion", want.to_empty, got.to_empty);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  task automatic queue_sample(input int ch, input int lvl,
                              input logic [drdm_pkg::TIME_W-1:0] t);
    sample_t s;
    s = '{ch[drdm_pkg::CH_W-1:0], lvl[drdm_pkg::LEVEL_W-1:0], t};
    pending_samples.insert(pending_samples.size(), s);
  endtask

  // Mostly plausible per-channel traces: time moves forward, level drifts down;
  // a few items step back in time, charge, jump or use a bad channel.
  task automatic queue_random_samples(input int count);
    sample_t s;
    int ch, pick, step;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 24) == 0) begin
        s.channel = drdm_pkg::CH_W'(drdm_pkg::CHANNELS_DEF);
        s.level = drdm_pkg::LEVEL_W'($urandom_range(0, LEVEL_TOP));
        s.stamp = $urandom;
      end else begin
        ch = $urandom_range(0, drdm_pkg::CHANNELS_DEF - 1);
        pick = $urandom_range(0, 99);
        if (pick < 3) step = 0;
        else if (pick < 6) step = -int'($urandom_range(1, 1000));
        else if (pick < 9) step = $urandom;
        else if (pick < 40) step = $urandom_range(1, 100);
        else step = $urandom_range(100, 5000);
        gen_time[ch] = gen_time[ch] + step;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          s.level = drdm_pkg::LEVEL_W'($urandom_range(drdm_pkg::LEVEL_MAX + 1, LEVEL_TOP));
          gen_level[ch] = drdm_pkg::LEVEL_MAX;
        end else begin
          if (pick < 10)
            gen_level[ch] = $urandom_range(0, drdm_pkg::LEVEL_MAX);
          else if (pick < 20)
            gen_level[ch] = gen_level[ch] + int'($urandom_range(1, 200));
          else
            gen_level[ch] = gen_level[ch] - int'($urandom_range(0, 40));
          if (gen_level[ch] > int'(drdm_pkg::LEVEL_MAX)) gen_level[ch] = drdm_pkg::LEVEL_MAX;
          if (gen_level[ch] < 0) gen_level[ch] = 0;
          s.level = drdm_pkg::LEVEL_W'(gen_level[ch]);
        end
        s.channel = drdm_pkg::CH_W'(ch);
        s.stamp = gen_time[ch];
      end
      pending_samples.insert(pending_samples.size(), s);
    end
  endtask

  // Block must be idle before a register write
  task automatic settle();
    while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [drdm_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[drdm_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == drdm_pkg::CFG_DRAIN_THRESHOLD) thr_reg = value[drdm_pkg::RATE_W-1:0];
    else crit_reg = value[drdm_pkg::CRIT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned thr, input int unsigned crit,
                                  input int count, input int pct);
    settle();
    write_reg(drdm_pkg::CFG_DRAIN_THRESHOLD, thr);
    write_reg(drdm_pkg::CFG_CRITICAL_LEVEL, crit);
    idle_pct = pct;
    queue_random_samples(count);
  endtask

  initial begin : stimulus
    for (int c = 0; c < drdm_pkg::CHANNELS_DEF; c++) begin
      gen_time[c] = $urandom;
      gen_level[c] = drdm_pkg::LEVEL_MAX;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items with the reset register values
    queue_sample(0, 10000, 1000);          // first sample: no rate yet
    queue_sample(0, 0, 1001);              // full drop in 1 ms: top rate
    queue_sample(0, 9990, 2000);
    queue_sample(0, 2500, 3000);           // level equal to critical
    queue_sample(0, 2501, 600000);
    queue_sample(1, 5000, 5);
    queue_sample(1, 4000, 5);              // zero elapsed time
    queue_sample(1, 3000, 3);              // time went backward
    queue_sample(1, 10000, 100);           // charging
    queue_sample(2, 10000, 32'hFFFF_FF00);
    queue_sample(2, 0, 32'h0000_0010);     // timestamp wrap
    queue_sample(2, 16383, 32'h0000_0020); // level above full scale
    queue_sample(2, 9999, 32'hFFFF_FFFF);
    queue_sample(3, 16383, 32'hFFFF_FFFF); // channel out of range
    queue_sample(3, 0, 0);

    run_random_phase(0, 0, 100, 25);
    settle();
    long_hold_req = 1'b1;
    run_random_phase(24'h7F_FFFF, drdm_pkg::LEVEL_MAX, 100, 5);
    run_random_phase(RATE_CAP, 8191, 100, 0);
    for (int p = 0; p < 3; p++)
      run_random_phase($urandom_range(0, 400), $urandom_range(0, drdm_pkg::LEVEL_MAX),
                       100, 30);
    // last stretch with no idling on either side
    run_random_phase(drdm_pkg::DRAIN_THRESHOLD_RST, drdm_pkg::CRITICAL_LEVEL_RST, 200, 0);

    settle();
    if (!failed && expected_reports.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
